// ===== rtl/csl_pkg.sv =====
// ----------------------------------------------------------------------------
// csl_pkg: shared definitions for the cubic soft limiter
// Default sample width and the sideband record that travels with each sample.
// ----------------------------------------------------------------------------
package csl_pkg;

    // default sample width (input Q4.(N-5), output Q1.(N-2))
    localparam int CSL_SAMPLE_BITS = 24;

    // per-sample control that rides alongside the datapath
    typedef struct packed {
        logic valid;
        logic last;
        logic neg;     // input sample was negative
        logic recip;   // |x| > 1.0, reciprocal branch
    } t_side;

endpackage

// ===== rtl/csl_cubic.sv =====
// ----------------------------------------------------------------------------
// csl_cubic: pipelined cubic branch, round(m - m^3/3)
// Magnitude in Q(F) input units, result in Q(G) output units. Six arithmetic
// stages, then a delay line so the result lines up with the divider.
// ----------------------------------------------------------------------------
module csl_cubic
    import csl_pkg::*;
#(
    parameter int SAMPLE_BITS = CSL_SAMPLE_BITS,
    parameter int LATENCY     = CSL_SAMPLE_BITS - 1
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [SAMPLE_BITS-5:0] i_mag,
    output logic [SAMPLE_BITS-3:0] o_mag
);

    localparam int F    = SAMPLE_BITS - 5;
    localparam int G    = SAMPLE_BITS - 2;
    localparam int CS   = 2 * SAMPLE_BITS - 13;
    localparam int MW   = F + 1;
    localparam int SQW  = 2 * MW;
    localparam int TLW  = MW;
    localparam int THW  = SQW - TLW;
    localparam int PW   = 2 * MW;
    localparam int NW   = 3 * F + 3;
    localparam int XW   = SAMPLE_BITS;
    localparam int S3   = SAMPLE_BITS + 2;
    localparam int PRW  = 2 * SAMPLE_BITS + 1;
    localparam int PAD  = LATENCY - 6;

    localparam logic [SQW-1:0]         THREE_SQ = SQW'(3) << (2 * F);
    localparam logic [NW-1:0]          HALF     = NW'(3) << (CS - 1);
    localparam logic [SAMPLE_BITS:0]   MAG3     =
        (SAMPLE_BITS + 1)'((64'd1 << S3) / 64'd3);

    // stage 1: m^2
    logic [MW-1:0]  r_m1;
    logic [SQW-1:0] r_sq;
    // stage 2: low partial product of m * (3 - m^2)
    logic [MW-1:0]  r_m2;
    logic [THW-1:0] r_th;
    logic [PW-1:0]  r_plo2;
    // stage 3: high partial product
    logic [PW-1:0]  r_plo3;
    logic [PW-1:0]  r_phi;
    // stage 4: scaled and rounded numerator (still times 3)
    logic [XW-1:0]  r_x4;
    // stage 5: reciprocal-multiply estimate of x/3
    logic [XW-1:0]  r_x5;
    logic [XW-1:0]  r_qe;
    // stage 6: corrected quotient
    logic [G-1:0]   r_q6;
    logic [G-1:0]   r_dly [PAD];

    logic [SQW-1:0] w_sq;
    logic [SQW-1:0] w_t;
    logic [PW-1:0]  w_plo;
    logic [PW-1:0]  w_phi;
    logic [NW-1:0]  w_n;
    logic [PRW-1:0] w_pr;
    logic [XW+1:0]  w_r;
    logic [XW-1:0]  w_q;

    assign w_sq  = SQW'(i_mag) * SQW'(i_mag);
    assign w_t   = THREE_SQ - r_sq;
    assign w_plo = PW'(r_m1) * PW'(w_t[TLW-1:0]);
    assign w_phi = PW'(r_m2) * PW'(r_th);
    assign w_n   = (NW'(r_phi) << TLW) + NW'(r_plo3) + HALF;
    assign w_pr  = PRW'(r_x4) * PRW'(MAG3);
    // estimate is exact or one low
    assign w_r   = (XW + 2)'(r_x5) - (((XW + 2)'(r_qe) << 1) + (XW + 2)'(r_qe));
    assign w_q   = (w_r >= (XW + 2)'(3)) ? (r_qe + XW'(1)) : r_qe;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m1   <= i_mag;
            r_sq   <= w_sq;
            r_m2   <= r_m1;
            r_th   <= w_t[SQW-1:TLW];
            r_plo2 <= w_plo;
            r_plo3 <= r_plo2;
            r_phi  <= w_phi;
            r_x4   <= XW'(w_n >> CS);
            r_x5   <= r_x4;
            r_qe   <= XW'(w_pr >> S3);
            r_q6   <= w_q[G-1:0];
            r_dly[0] <= r_q6;
            for (int k = 1; k < PAD; k++) begin
                r_dly[k] <= r_dly[k-1];
            end
        end
    end

    assign o_mag = r_dly[PAD-1];

endmodule

// ===== rtl/csl_recip.sv =====
// ----------------------------------------------------------------------------
// csl_recip: pipelined reciprocal branch, round(1 - 1/(3x))
// Restoring division of 2^(2N-6) by 3m, one quotient bit per stage, then a
// round-and-subtract stage.
// ----------------------------------------------------------------------------
module csl_recip
    import csl_pkg::*;
#(
    parameter int SAMPLE_BITS = CSL_SAMPLE_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [SAMPLE_BITS:0]   i_den,
    output logic [SAMPLE_BITS-3:0] o_mag
);

    localparam int D  = SAMPLE_BITS - 2;   // quotient bits (= output frac bits)
    localparam int DW = SAMPLE_BITS + 1;   // divisor / remainder width

    // top part of the power-of-two dividend, already below the divisor
    localparam logic [DW-1:0] REM0 = DW'(1) << (SAMPLE_BITS - 4);
    localparam logic [D:0]    ONE  = (D + 1)'(1) << D;

    logic [DW-1:0] r_rem [D-1];
    logic [DW-1:0] r_den [D-1];
    logic [D-1:0]  r_quo [D];
    logic [D-1:0]  r_y;

    logic [DW-1:0] w_rin [D];
    logic [DW-1:0] w_din [D];
    logic [D-1:0]  w_qin [D];
    logic [DW:0]   w_sh  [D];
    logic [DW-1:0] w_rnx [D];
    logic [D-1:0]  w_ge;
    logic [D:0]    w_qr;
    logic [D:0]    w_y;

    always_comb begin
        w_rin[0] = REM0;
        w_din[0] = i_den;
        w_qin[0] = '0;
        for (int i = 1; i < D; i++) begin
            w_rin[i] = r_rem[i-1];
            w_din[i] = r_den[i-1];
            w_qin[i] = r_quo[i-1];
        end
        for (int i = 0; i < D; i++) begin
            w_sh[i]  = {w_rin[i], 1'b0};
            w_ge[i]  = (w_sh[i] >= {1'b0, w_din[i]});
            w_rnx[i] = w_ge[i] ? DW'(w_sh[i] - {1'b0, w_din[i]}) : w_sh[i][DW-1:0];
        end
    end

    // quotient carries one extra bit; no ties since the divisor holds a 3
    assign w_qr = (D + 1)'(r_quo[D-1]) + (D + 1)'(1);
    assign w_y  = ONE - {1'b0, w_qr[D:1]};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < D; i++) begin
                r_quo[i] <= {w_qin[i][D-2:0], w_ge[i]};
            end
            for (int i = 0; i < D - 1; i++) begin
                r_rem[i] <= w_rnx[i];
                r_den[i] <= w_din[i];
            end
            r_y <= w_y[D-1:0];
        end
    end

    assign o_mag = r_y;

endmodule

// ===== rtl/cubic_soft_limiter.sv =====
// ----------------------------------------------------------------------------
// cubic_soft_limiter: per-sample cubic soft limiter, fixed point
// Q4.(N-5) in, Q1.(N-2) out; x - x^3/3 inside +-1, +-1 - 1/(3x) outside.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_valid / o_stall with i_sample_in and i_last_in. A
//   transaction completes on a rising edge with i_valid high and o_stall low.
//   Output channel: o_valid / i_stall with o_sample_out and o_last_out.
//   o_last_out is i_last_in of the same sample.
//   Throughput: one sample per clock, sustained while i_stall is low.
//   Pipeline: the reciprocal divider sets the depth. It resolves one
//   quotient bit per stage, SAMPLE_BITS-2 stages, plus two front stages
//   (sign/magnitude, then branch select and 3x), a rounding stage and the
//   output register. The cubic branch runs alongside, delayed to match.
//   Stall: while o_valid is high and i_stall is asserted the whole pipeline
//   freezes. A one-entry skid register at the input absorbs the transaction
//   that arrives in that cycle; o_stall is the skid's full flag, so it comes
//   straight from a flop.
//   Reset (i_rst_n low, synchronous): all valid bits and the skid clear;
//   samples in flight are dropped. There is no configuration.
// ----------------------------------------------------------------------------
module cubic_soft_limiter
    import csl_pkg::*;
#(
    parameter int SAMPLE_BITS = CSL_SAMPLE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_in,
    input  logic                          i_last_in,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [SAMPLE_BITS-1:0] o_sample_out,
    output logic                          o_last_out
);

    localparam int W   = SAMPLE_BITS;
    localparam int F   = W - 5;            // input fraction bits
    localparam int G   = W - 2;            // output fraction bits
    localparam int LAT = W - 1;            // branch pipelines: G divider stages + round

    localparam logic [W-1:0]        ONE_IN    = W'(1) << F;
    localparam logic signed [W-1:0] ONE_OUT   = W'(1) << G;
    localparam logic signed [W-1:0] M_ONE_OUT = W'(0) - (W'(1) << G);

    // input skid
    logic             r_skid_valid;
    logic [W-1:0]     r_skid_sample;
    logic             r_skid_last;

    // stage A: sign and magnitude
    t_side            r_a_side;
    logic [W-1:0]     r_a_mag;
    // stage B: branch select, divisor, cubic operand
    t_side            r_b_side;
    logic [W:0]       r_b_den;
    logic [F:0]       r_b_cmag;
    // sideband delay matching the branch pipelines
    t_side            r_side_dly [LAT];
    // output register
    t_side            r_out_side;
    logic [W-1:0]     r_out_sample;

    logic             w_adv;
    logic             w_in_valid;
    logic [W-1:0]     w_in_sample;
    logic             w_in_last;
    logic             w_in_neg;
    logic             w_recip;
    logic [G-1:0]     w_y_cubic;
    logic [G-1:0]     w_y_recip;
    logic [W-1:0]     w_mag;
    t_side            w_tail;

    // the pipeline moves unless a finished sample is held at the output
    assign w_adv = !r_out_side.valid || !i_stall;

    assign w_in_valid  = r_skid_valid || i_valid;
    assign w_in_sample = r_skid_valid ? r_skid_sample : i_sample_in;
    assign w_in_last   = r_skid_valid ? r_skid_last : i_last_in;
    assign w_in_neg    = w_in_sample[W-1];

    assign o_stall = r_skid_valid;

    // skid control: fill when frozen, drain when moving
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_valid <= 1'b0;
        end else if (w_adv) begin
            r_skid_valid <= 1'b0;
        end else if (i_valid && !r_skid_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_adv && i_valid && !r_skid_valid) begin
            r_skid_sample <= i_sample_in;
            r_skid_last   <= i_last_in;
        end
    end

    // magnitude above 1.0 takes the reciprocal branch; exactly 1.0 stays cubic
    assign w_recip = r_a_mag > ONE_IN;

    // sideband pipeline (valid bits reset)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_side   <= '0;
            r_b_side   <= '0;
            r_out_side <= '0;
            for (int k = 0; k < LAT; k++) begin
                r_side_dly[k] <= '0;
            end
        end else if (w_adv) begin
            r_a_side.valid <= w_in_valid;
            r_a_side.last  <= w_in_last;
            r_a_side.neg   <= w_in_neg;
            r_a_side.recip <= 1'b0;
            r_b_side.valid <= r_a_side.valid;
            r_b_side.last  <= r_a_side.last;
            r_b_side.neg   <= r_a_side.neg;
            r_b_side.recip <= w_recip;
            r_side_dly[0]  <= r_b_side;
            for (int k = 1; k < LAT; k++) begin
                r_side_dly[k] <= r_side_dly[k-1];
            end
            r_out_side <= r_side_dly[LAT-1];
        end
    end

    assign w_tail = r_side_dly[LAT-1];
    assign w_mag  = W'(w_tail.recip ? w_y_recip : w_y_cubic);

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a_mag      <= w_in_neg ? (~w_in_sample + W'(1)) : w_in_sample;
            r_b_den      <= {1'b0, r_a_mag} + {r_a_mag, 1'b0};
            // cubic branch gets zero when unused, keeping its operand in range
            r_b_cmag     <= w_recip ? '0 : r_a_mag[F:0];
            r_out_sample <= w_tail.neg ? (W'(0) - w_mag) : w_mag;
        end
    end

    csl_cubic #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .LATENCY     (LAT)
    ) u_cubic (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_mag (r_b_cmag),
        .o_mag (w_y_cubic)
    );

    csl_recip #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_recip (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_den (r_b_den),
        .o_mag (w_y_recip)
    );

    assign o_valid      = r_out_side.valid;
    assign o_last_out   = r_out_side.last;
    assign o_sample_out = $signed(r_out_sample);

    // skid never holds across a cycle in which the pipeline moved
    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && w_adv) |=> !r_skid_valid)
        else $error("skid entry not drained while pipeline advanced");

    // a transaction that arrives during a freeze is caught by the skid
    a_skid_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !r_skid_valid && !w_adv) |=> r_skid_valid)
        else $error("transaction arriving during freeze not captured");

    // limiter output stays within [-1, 1]
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_sample_out <= ONE_OUT) && (o_sample_out >= M_ONE_OUT))
        else $error("output sample outside [-1, 1]");

endmodule
